[hw/rtl/rti_pkg.sv]
`default_nettype none
package rti_pkg;

    // field widths
    localparam int CW       = 32;           // coordinate, signed Q16.16
    localparam int TAG_BITS = 24;           // triangle tag
    localparam int EW       = CW + 1;       // vertex difference
    localparam int NW       = 67;           // exact face normal component
    localparam int FNW      = 64;           // saturated normal on the output
    localparam int DW       = 101;          // exact n.D and n.(A-S)
    localparam int QW       = 33;           // fraction, Q0.32 with room for 1.0
    localparam int RW       = DW + QW;      // divider remainder
    localparam int PW       = 35;           // exact hit point component
    localparam int DDW      = PW + 1;       // hit point minus vertex
    localparam int XW       = 70;           // edge cross product component
    localparam int MW       = 72;           // multiplier operand
    localparam int MPW      = 2 * MW;       // multiplier product
    localparam int SUMW     = MPW + 2;      // three-term dot product

    localparam int DIV_STAGES = QW;         // one quotient bit per stage
    localparam int QDEPTH     = 4;          // candidate queue depth
    localparam int QAW        = $clog2(QDEPTH);

    // configuration register index
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_START_Z = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DIR_X   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_DIR_Y   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_DIR_Z   = 3'd5;

    typedef logic [2:0][CW-1:0] t_vec3;
    typedef logic [2:0][NW-1:0] t_nvec;

    typedef struct packed {
        t_vec3 s;
        t_vec3 d;
    } t_ray;

    typedef struct packed {
        t_vec3               a;
        t_vec3               b;
        t_vec3               c;
        logic [TAG_BITS-1:0] tag;
    } t_tri;

    // triangle that passed the facing and range tests
    typedef struct packed {
        t_tri          face;
        t_nvec         n;
        logic [DW-1:0] den;
        logic [DW-1:0] num;
    } t_cand;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

[hw/rtl/ray_triangle_intersect.sv]
`default_nettype none
// throughput: one triangle per clock; the fixed pipeline, the 33-stage divider and the
// back end all advance every cycle, and busy rises only when the candidate queue is full
// a miss produces no strobe; the receiver cannot stall, each hit shows for one cycle
// reset: synchronous active-low; clears the ray registers to zero and drops all
// transactions in flight
module ray_triangle_intersect (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_cfg_we,
    input  logic [rti_pkg::CFG_IW-1:0]            i_cfg_idx,
    input  logic [rti_pkg::CW-1:0]                i_cfg_data,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_a_x,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_a_y,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_a_z,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_b_x,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_b_y,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_b_z,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_c_x,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_c_y,
    input  logic signed [rti_pkg::CW-1:0]         i_corner_c_z,
    input  logic [rti_pkg::TAG_BITS-1:0]          i_triangle_tag,
    output logic                                  o_hit_valid,
    output logic [rti_pkg::QW-1:0]                o_hit_fraction,
    output logic signed [rti_pkg::CW-1:0]         o_hit_point_x,
    output logic signed [rti_pkg::CW-1:0]         o_hit_point_y,
    output logic signed [rti_pkg::CW-1:0]         o_hit_point_z,
    output logic signed [rti_pkg::FNW-1:0]        o_face_normal_x,
    output logic signed [rti_pkg::FNW-1:0]        o_face_normal_y,
    output logic signed [rti_pkg::FNW-1:0]        o_face_normal_z,
    output logic [rti_pkg::TAG_BITS-1:0]          o_hit_tag
);
    import rti_pkg::*;

    t_ray                 r_ray;
    t_tri                 w_tri;
    t_cand                w_fcand, w_qcand;
    t_qstat               w_qstat;
    logic                 w_accept, w_push, w_pop;
    t_vec3                w_point;
    logic [2:0][FNW-1:0]  w_normal;

    // ray registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_X: r_ray.s[0] <= i_cfg_data;
                REG_START_Y: r_ray.s[1] <= i_cfg_data;
                REG_START_Z: r_ray.s[2] <= i_cfg_data;
                REG_DIR_X:   r_ray.d[0] <= i_cfg_data;
                REG_DIR_Y:   r_ray.d[1] <= i_cfg_data;
                REG_DIR_Z:   r_ray.d[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input transaction
    assign busy     = w_qstat.full;
    assign w_accept = start && !busy;
    assign w_tri.a  = {i_corner_a_z, i_corner_a_y, i_corner_a_x};
    assign w_tri.b  = {i_corner_b_z, i_corner_b_y, i_corner_b_x};
    assign w_tri.c  = {i_corner_c_z, i_corner_c_y, i_corner_c_x};
    assign w_tri.tag = i_triangle_tag;

    rti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_tri   (w_tri),
        .i_ray   (r_ray),
        .o_push  (w_push),
        .o_cand  (w_fcand)
    );

    rti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fcand),
        .i_pop   (w_pop),
        .o_data  (w_qcand),
        .o_stat  (w_qstat)
    );

    // back end takes a candidate every cycle while the queue is not empty
    assign w_pop = !w_qstat.empty;

    rti_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_pop),
        .i_cand     (w_qcand),
        .i_ray      (r_ray),
        .o_valid    (o_hit_valid),
        .o_fraction (o_hit_fraction),
        .o_point    (w_point),
        .o_normal   (w_normal),
        .o_tag      (o_hit_tag)
    );

    assign o_hit_point_x   = w_point[0];
    assign o_hit_point_y   = w_point[1];
    assign o_hit_point_z   = w_point[2];
    assign o_face_normal_x = w_normal[0];
    assign o_face_normal_y = w_normal[1];
    assign o_face_normal_z = w_normal[2];

`ifndef ASSERT_OFF
    // fraction never exceeds one
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit_valid && o_hit_fraction[QW-1]) |-> (o_hit_fraction[QW-2:0] == '0))
        else $error("hit fraction above one");

    // queue is never written while full unless it is also read in the same cycle
    a_queue_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full && !w_pop))
        else $error("candidate queue overflow");

    // no strobe right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_hit_valid)
        else $error("hit strobe after reset");
`endif

endmodule
`default_nettype wire

[hw/rtl/rti_mul.sv]
`default_nettype none
module rti_mul (
    input  logic                       i_clk,
    input  logic signed [rti_pkg::MW-1:0]  i_a,
    input  logic signed [rti_pkg::MW-1:0]  i_b,
    output logic        [rti_pkg::MPW-1:0] o_p
);
    import rti_pkg::*;

    localparam int HW = MW / 2;

    logic signed [HW:0]     w_al, w_ah, w_bl, w_bh;
    logic signed [2*HW+1:0] r_ll, r_lh, r_hl, r_hh;

    // split into unsigned low and signed high halves
    assign w_al = $signed({1'b0, i_a[HW-1:0]});
    assign w_ah = $signed({i_a[MW-1], i_a[MW-1:HW]});
    assign w_bl = $signed({1'b0, i_b[HW-1:0]});
    assign w_bh = $signed({i_b[MW-1], i_b[MW-1:HW]});

    // partial products
    always_ff @(posedge i_clk) begin
        r_ll <= w_al * w_bl;
        r_lh <= w_al * w_bh;
        r_hl <= w_ah * w_bl;
        r_hh <= w_ah * w_bh;
    end

    // recombine
    always_ff @(posedge i_clk) begin
        o_p <= (MPW'(r_hh) << (2 * HW)) + (MPW'(r_lh) << HW)
             + (MPW'(r_hl) << HW) + MPW'(r_ll);
    end

endmodule
`default_nettype wire

[hw/rtl/rti_front.sv]
`default_nettype none
module rti_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rti_pkg::t_tri   i_tri,
    input  rti_pkg::t_ray   i_ray,
    output logic            o_push,
    output rti_pkg::t_cand  o_cand
);
    import rti_pkg::*;

    logic [7:0]           r_v;
    t_tri                 r_tri [8];
    logic [2:0][EW-1:0]   r_e1, r_e2;
    logic [2:0][EW-1:0]   r_as [1:4];
    t_nvec                r_n [4:7];
    logic [DW-1:0]        r_den, r_num;
    logic [2:0][MPW-1:0]  w_pa, w_pb, w_pd, w_pm;
    logic                 w_den_neg, w_num_ok, w_rng_ok;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_tri[0] <= i_tri;
        end
        for (int k = 1; k < 8; k++) begin
            r_tri[k] <= r_tri[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_e1[i]    <= EW'($signed(r_tri[0].b[i])) - EW'($signed(r_tri[0].a[i]));
            r_e2[i]    <= EW'($signed(r_tri[0].c[i])) - EW'($signed(r_tri[0].a[i]));
            r_as[1][i] <= EW'($signed(r_tri[0].a[i])) - EW'($signed(i_ray.s[i]));
            r_n[4][i]  <= NW'($signed(w_pa[i]) - $signed(w_pb[i]));
        end
        for (int k = 2; k <= 4; k++) begin
            r_as[k] <= r_as[k-1];
        end
        for (int k = 5; k <= 7; k++) begin
            r_n[k] <= r_n[k-1];
        end
        r_den <= DW'(w_pd[0] + w_pd[1] + w_pd[2]);
        r_num <= DW'(w_pm[0] + w_pm[1] + w_pm[2]);
    end

    // face normal and the two dot products
    for (genvar i = 0; i < 3; i++) begin : g_vec
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        rti_mul u_pa (
            .i_clk (i_clk),
            .i_a   (MW'($signed(r_e1[J]))),
            .i_b   (MW'($signed(r_e2[K]))),
            .o_p   (w_pa[i])
        );
        rti_mul u_pb (
            .i_clk (i_clk),
            .i_a   (MW'($signed(r_e1[K]))),
            .i_b   (MW'($signed(r_e2[J]))),
            .o_p   (w_pb[i])
        );
        rti_mul u_pd (
            .i_clk (i_clk),
            .i_a   (MW'($signed(r_n[4][i]))),
            .i_b   (MW'($signed(i_ray.d[i]))),
            .o_p   (w_pd[i])
        );
        rti_mul u_pm (
            .i_clk (i_clk),
            .i_a   (MW'($signed(r_n[4][i]))),
            .i_b   (MW'($signed(r_as[4][i]))),
            .o_p   (w_pm[i])
        );
    end

    // front facing, in front of start, not past the end
    assign w_den_neg = r_den[DW-1];
    assign w_num_ok  = r_num[DW-1] || (r_num == '0);
    assign w_rng_ok  = $signed(r_num) >= $signed(r_den);
    assign o_push    = r_v[7] && w_den_neg && w_num_ok && w_rng_ok;

    assign o_cand.face = r_tri[7];
    assign o_cand.n    = r_n[7];
    assign o_cand.den  = r_den;
    assign o_cand.num  = r_num;

endmodule
`default_nettype wire

[hw/rtl/rti_queue.sv]
`default_nettype none
module rti_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rti_pkg::t_cand   i_data,
    input  logic             i_pop,
    output rti_pkg::t_cand   o_data,
    output rti_pkg::t_qstat  o_stat
);
    import rti_pkg::*;

    t_cand            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule
`default_nettype wire

[hw/rtl/rti_back.sv]
`default_nettype none
module rti_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rti_pkg::t_cand                i_cand,
    input  rti_pkg::t_ray                 i_ray,
    output logic                          o_valid,
    output logic [rti_pkg::QW-1:0]        o_fraction,
    output rti_pkg::t_vec3                o_point,
    output logic [2:0][rti_pkg::FNW-1:0]  o_normal,
    output logic [rti_pkg::TAG_BITS-1:0]  o_tag
);
    import rti_pkg::*;

    typedef struct packed {
        t_tri  face;
        t_nvec n;
    } t_item;

    typedef logic [2:0][PW-1:0] t_pvec;

    function automatic logic [CW-1:0] sat32(input logic [PW-1:0] v);
        logic fits;
        fits = (v[PW-1:CW-1] == '0) || (v[PW-1:CW-1] == '1);
        return fits ? v[CW-1:0]
                    : (v[PW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
    endfunction

    function automatic logic [FNW-1:0] sat64(input logic [NW-1:0] v);
        logic fits;
        fits = (v[NW-1:FNW-1] == '0) || (v[NW-1:FNW-1] == '1);
        return fits ? v[FNW-1:0]
                    : (v[NW-1] ? {1'b1, {(FNW-1){1'b0}}} : {1'b0, {(FNW-1){1'b1}}});
    endfunction

    // divider pipeline
    logic [DIV_STAGES:0]  r_dv;
    logic [RW-1:0]        r_rem [DIV_STAGES+1];
    logic [DW-1:0]        r_dd  [DIV_STAGES+1];
    logic [QW-1:0]        r_q   [DIV_STAGES+1];
    t_item                r_di  [DIV_STAGES+1];
    logic [DW-1:0]        w_nnum, w_nden;

    // hit point and edge pipeline
    logic [9:1]                    r_hv;
    logic [QW-1:0]                 r_hq [1:9];
    t_item                         r_hi [1:9];
    t_pvec                         r_pt [3:9];
    logic [2:0][2:0][EW-1:0]       r_ee;
    logic [2:0][2:0][DDW-1:0]      r_ed;
    logic [2:0][2:0][XW-1:0]       r_xc;
    logic [2:0][MPW-1:0]           w_ph;
    logic [2:0][2:0][MPW-1:0]      w_xa, w_xb, w_xd;
    t_vec3                         w_vtx [3];
    logic [2:0][SUMW-1:0]          w_sum;
    logic                          w_hit;

    assign w_nnum = DW'(0) - i_cand.num;
    assign w_nden = DW'(0) - i_cand.den;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv    <= '0;
            r_hv    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_dv    <= {r_dv[DIV_STAGES-1:0], i_valid};
            r_hv    <= {r_hv[8:1], r_dv[DIV_STAGES]};
            o_valid <= w_hit;
        end
    end

    // divider load: -num scaled by 2^32 over -den
    always_ff @(posedge i_clk) begin
        r_rem[0]     <= {1'b0, w_nnum, {(QW-1){1'b0}}};
        r_dd[0]      <= w_nden;
        r_q[0]       <= '0;
        r_di[0].face <= i_cand.face;
        r_di[0].n    <= i_cand.n;
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        localparam int SH = DIV_STAGES - 1 - k;
        logic [RW:0] w_t;

        assign w_t = {1'b0, r_rem[k]} - ((RW+1)'(r_dd[k]) << SH);

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= w_t[RW] ? r_rem[k] : w_t[RW-1:0];
            r_q[k+1]   <= r_q[k] | (w_t[RW] ? QW'(0) : (QW'(1) << SH));
            r_dd[k+1]  <= r_dd[k];
            r_di[k+1]  <= r_di[k];
        end
    end

    // hit point offset q * D
    for (genvar i = 0; i < 3; i++) begin : g_pt
        rti_mul u_ph (
            .i_clk (i_clk),
            .i_a   ($signed(MW'(r_q[DIV_STAGES]))),
            .i_b   (MW'($signed(i_ray.d[i]))),
            .o_p   (w_ph[i])
        );
    end

    assign w_vtx[0] = r_hi[3].face.a;
    assign w_vtx[1] = r_hi[3].face.b;
    assign w_vtx[2] = r_hi[3].face.c;

    // hit point, edge vectors and edge cross products
    always_ff @(posedge i_clk) begin
        r_hq[1] <= r_q[DIV_STAGES];
        r_hi[1] <= r_di[DIV_STAGES];
        for (int k = 2; k <= 9; k++) begin
            r_hq[k] <= r_hq[k-1];
            r_hi[k] <= r_hi[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_pt[3][i] <= PW'($signed(i_ray.s[i])) + w_ph[i][CW+PW-1:CW];
        end
        for (int k = 4; k <= 9; k++) begin
            r_pt[k] <= r_pt[k-1];
        end
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                r_ee[j][i] <= EW'($signed(w_vtx[(j+1)%3][i])) - EW'($signed(w_vtx[j][i]));
                r_ed[j][i] <= DDW'($signed(r_pt[3][i])) - DDW'($signed(w_vtx[j][i]));
                r_xc[j][i] <= XW'($signed(w_xa[j][i]) - $signed(w_xb[j][i]));
            end
        end
    end

    // edge tests: (e x (p - v)) . n
    for (genvar j = 0; j < 3; j++) begin : g_edge
        for (genvar i = 0; i < 3; i++) begin : g_comp
            localparam int J = (i + 1) % 3;
            localparam int K = (i + 2) % 3;

            rti_mul u_xa (
                .i_clk (i_clk),
                .i_a   (MW'($signed(r_ee[j][J]))),
                .i_b   (MW'($signed(r_ed[j][K]))),
                .o_p   (w_xa[j][i])
            );
            rti_mul u_xb (
                .i_clk (i_clk),
                .i_a   (MW'($signed(r_ee[j][K]))),
                .i_b   (MW'($signed(r_ed[j][J]))),
                .o_p   (w_xb[j][i])
            );
            rti_mul u_xd (
                .i_clk (i_clk),
                .i_a   (MW'($signed(r_xc[j][i]))),
                .i_b   (MW'($signed(r_hi[7].n[i]))),
                .o_p   (w_xd[j][i])
            );
        end
        assign w_sum[j] = SUMW'($signed(w_xd[j][0])) + SUMW'($signed(w_xd[j][1]))
                        + SUMW'($signed(w_xd[j][2]));
    end

    // the edge-test signs of every edge agree
    assign w_hit = r_hv[9] && (w_sum[0][SUMW-1] == w_sum[1][SUMW-1])
                           && (w_sum[0][SUMW-1] == w_sum[2][SUMW-1]);

    // result register
    always_ff @(posedge i_clk) begin
        o_fraction <= r_hq[9];
        o_tag      <= r_hi[9].face.tag;
        for (int i = 0; i < 3; i++) begin
            o_point[i]  <= sat32(r_pt[9][i]);
            o_normal[i] <= sat64(r_hi[9].n[i]);
        end
    end

endmodule
`default_nettype wire
